[hdl/hrhp_pkg.sv]
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types, constants and the per-byte field step shared by the HTTP request
// head parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_PATH    = 3'd1,
        PH_VERSION = 3'd2,
        PH_LINE    = 3'd3,
        PH_NAME    = 3'd4,
        PH_SKIP    = 3'd5,
        PH_VALUE   = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    // field_kind codes
    localparam logic [2:0] KIND_VERDICT = 3'd0;
    localparam logic [2:0] KIND_METHOD  = 3'd1;
    localparam logic [2:0] KIND_PATH    = 3'd2;
    localparam logic [2:0] KIND_VERSION = 3'd3;
    localparam logic [2:0] KIND_NAME    = 3'd4;
    localparam logic [2:0] KIND_VALUE   = 3'd5;

    // status codes
    localparam logic [1:0] STAT_PARSING  = 2'd0;
    localparam logic [1:0] STAT_ACCEPTED = 2'd1;
    localparam logic [1:0] STAT_REJECTED = 2'd2;

    // Special bytes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Configuration register indexes
    localparam logic [2:0] REG_METHOD_LIMIT  = 3'd0;
    localparam logic [2:0] REG_PATH_LIMIT    = 3'd1;
    localparam logic [2:0] REG_VERSION_LIMIT = 3'd2;
    localparam logic [2:0] REG_NAME_LIMIT    = 3'd3;
    localparam logic [2:0] REG_VALUE_LIMIT   = 3'd4;
    localparam logic [2:0] REG_HEADER_LIMIT  = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int LEN_W      = 13;
    localparam int HCNT_W     = 7;

    // Output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef struct packed {
        logic [4:0]  method_lim;
        logic [12:0] path_lim;
        logic [6:0]  version_lim;
        logic [8:0]  name_lim;
        logic [12:0] value_lim;
        logic [6:0]  header_lim;
    } limits_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic [2:0] field_kind;
        logic [5:0] header_index;
        logic [1:0] status;
        logic [6:0] header_total;
        logic       last_of_run;
    } result_t;

    // Up to two results written per accepted byte
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed {
        phase_t          ph;
        logic [LEN_W-1:0] len;
        logic            reject;
        logic            emit;
        logic [2:0]      kind;
    } take_t;

    // One byte that is not part of a CRLF
    function automatic take_t take_byte(
        input phase_t           ph,
        input logic [LEN_W-1:0] len,
        input logic [HCNT_W-1:0] hc,
        input logic [7:0]       b,
        input limits_t          lim
    );
        take_t            r;
        phase_t           ep;
        phase_t           end_ph;
        phase_t           byte_ph;
        logic [LEN_W-1:0] el;
        logic [LEN_W-1:0] limv;
        logic             is_end;
        logic             is_byte;
        logic [2:0]       kind;
        r.ph     = ph;
        r.len    = len;
        r.reject = 1'b0;
        r.emit   = 1'b0;
        r.kind   = KIND_VERDICT;
        ep       = ph;
        el       = len;
        end_ph   = ph;
        byte_ph  = ph;
        is_end   = 1'b0;
        is_byte  = 1'b0;
        kind     = KIND_VERDICT;
        // a header line starts here
        if (ph == PH_LINE) begin
            if (hc >= lim.header_lim) begin
                r.reject = 1'b1;
            end
            else begin
                ep = PH_NAME;
                el = '0;
            end
        end
        unique case (ep)
            PH_METHOD:  limv = LEN_W'(lim.method_lim);
            PH_PATH:    limv = lim.path_lim;
            PH_VERSION: limv = LEN_W'(lim.version_lim);
            PH_NAME:    limv = LEN_W'(lim.name_lim);
            default:    limv = lim.value_lim;
        endcase
        if (!r.reject) begin
            unique case (ep)
                PH_METHOD:
                begin
                    is_end  = (b == CH_SP);
                    is_byte = (b != CH_SP);
                    end_ph  = PH_PATH;
                    byte_ph = PH_METHOD;
                    kind    = KIND_METHOD;
                end
                PH_PATH:
                begin
                    is_end  = (b == CH_SP);
                    is_byte = (b != CH_SP);
                    end_ph  = PH_VERSION;
                    byte_ph = PH_PATH;
                    kind    = KIND_PATH;
                end
                PH_VERSION:
                begin
                    is_byte = 1'b1;
                    byte_ph = PH_VERSION;
                    kind    = KIND_VERSION;
                end
                PH_NAME:
                begin
                    is_end  = (b == CH_COLON);
                    is_byte = (b != CH_COLON);
                    end_ph  = PH_SKIP;
                    byte_ph = PH_NAME;
                    kind    = KIND_NAME;
                end
                PH_SKIP:
                begin
                    // leading spaces of the value are dropped
                    is_byte = (b != CH_SP);
                    byte_ph = PH_VALUE;
                    kind    = KIND_VALUE;
                end
                PH_VALUE:
                begin
                    is_byte = 1'b1;
                    byte_ph = PH_VALUE;
                    kind    = KIND_VALUE;
                end
                default:
                begin
                    is_byte = 1'b0;
                end
            endcase
            if (is_end) begin
                if (el >= limv) begin
                    r.reject = 1'b1;
                end
                else begin
                    r.ph  = end_ph;
                    r.len = '0;
                end
            end
            if (is_byte) begin
                if (({1'b0, el} + (LEN_W+1)'(1)) >= {1'b0, limv}) begin
                    r.reject = 1'b1;
                end
                else begin
                    r.ph   = byte_ph;
                    r.len  = el + LEN_W'(1);
                    r.emit = 1'b1;
                    r.kind = kind;
                end
            end
        end
        return r;
    endfunction

endpackage

[hdl/hrhp_cfg.sv]
// ----------------------------------------------------------------------------
// hrhp_cfg
// Limit registers, written through the plain configuration write port.
// ----------------------------------------------------------------------------
module hrhp_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hrhp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hrhp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output hrhp_pkg::limits_t                lim
);

    hrhp_pkg::limits_t lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lim_reg.method_lim  <= 5'd8;
            lim_reg.path_lim    <= 13'd256;
            lim_reg.version_lim <= 7'd16;
            lim_reg.name_lim    <= 9'd64;
            lim_reg.value_lim   <= 13'd256;
            lim_reg.header_lim  <= 7'd32;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                hrhp_pkg::REG_METHOD_LIMIT:  lim_reg.method_lim  <= cfg_data[4:0];
                hrhp_pkg::REG_PATH_LIMIT:    lim_reg.path_lim    <= cfg_data[12:0];
                hrhp_pkg::REG_VERSION_LIMIT: lim_reg.version_lim <= cfg_data[6:0];
                hrhp_pkg::REG_NAME_LIMIT:    lim_reg.name_lim    <= cfg_data[8:0];
                hrhp_pkg::REG_VALUE_LIMIT:   lim_reg.value_lim   <= cfg_data[12:0];
                hrhp_pkg::REG_HEADER_LIMIT:  lim_reg.header_lim  <= cfg_data[6:0];
                default:                     lim_reg             <= lim_reg;
            endcase
        end
    end

    assign lim = lim_reg;

endmodule

[hdl/hrhp_parse.sv]
// ----------------------------------------------------------------------------
// hrhp_parse
// Parse state registers and the combinational byte step. Produces zero, one
// or two results for each accepted byte.
// ----------------------------------------------------------------------------
module hrhp_parse
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               end_of_request,
    input  hrhp_pkg::limits_t  lim,
    output hrhp_pkg::push_t    push
);

    hrhp_pkg::phase_t                  ph_reg, ph_next;
    logic                              cr_reg, cr_next;
    logic [hrhp_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [hrhp_pkg::HCNT_W-1:0]       hc_reg, hc_next;

    hrhp_pkg::take_t                   t_cr;
    hrhp_pkg::take_t                   t_after_cr;
    hrhp_pkg::take_t                   t_plain;

    logic [1:0]                        verdict;
    logic [hrhp_pkg::HCNT_W-1:0]       hc_step;
    logic                              e0, e1;
    logic [7:0]                        c0, c1;
    logic [2:0]                        k0, k1;
    hrhp_pkg::result_t                 res0, res1;

    assign t_cr       = hrhp_pkg::take_byte(ph_reg, len_reg, hc_reg, hrhp_pkg::CH_CR, lim);
    assign t_after_cr = hrhp_pkg::take_byte(t_cr.ph, t_cr.len, hc_reg, data_byte, lim);
    assign t_plain    = hrhp_pkg::take_byte(ph_reg, len_reg, hc_reg, data_byte, lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ph_reg  <= hrhp_pkg::PH_METHOD;
            cr_reg  <= 1'b0;
            len_reg <= '0;
            hc_reg  <= '0;
        end
        else if (accept) begin
            ph_reg  <= ph_next;
            cr_reg  <= cr_next;
            len_reg <= len_next;
            hc_reg  <= hc_next;
        end
    end

    always_comb
    begin
        ph_next  = ph_reg;
        cr_next  = cr_reg;
        len_next = len_reg;
        hc_step  = hc_reg;
        hc_next  = hc_reg;
        verdict  = hrhp_pkg::STAT_PARSING;
        e0       = 1'b0;
        e1       = 1'b0;
        c0       = hrhp_pkg::CH_CR;
        c1       = data_byte;
        k0       = hrhp_pkg::KIND_VERDICT;
        k1       = hrhp_pkg::KIND_VERDICT;
        res0     = '0;
        res1     = '0;
        push     = '0;

        if (ph_reg == hrhp_pkg::PH_DONE) begin
            // waiting for end of request; no results
            if (end_of_request) begin
                ph_next  = hrhp_pkg::PH_METHOD;
                cr_next  = 1'b0;
                len_next = '0;
                hc_next  = '0;
            end
        end
        else begin
            if (data_byte == hrhp_pkg::CH_NUL) begin
                verdict = hrhp_pkg::STAT_REJECTED;
            end
            else if (cr_reg) begin
                cr_next = 1'b0;
                if (data_byte == hrhp_pkg::CH_LF) begin
                    // CRLF: close the line
                    unique case (ph_reg)
                        hrhp_pkg::PH_VERSION:
                        begin
                            if (len_reg >= hrhp_pkg::LEN_W'(lim.version_lim)) begin
                                verdict = hrhp_pkg::STAT_REJECTED;
                            end
                            else begin
                                ph_next  = hrhp_pkg::PH_LINE;
                                len_next = '0;
                            end
                        end
                        hrhp_pkg::PH_LINE:
                        begin
                            verdict = hrhp_pkg::STAT_ACCEPTED;
                        end
                        hrhp_pkg::PH_SKIP, hrhp_pkg::PH_VALUE:
                        begin
                            if (len_reg >= lim.value_lim) begin
                                verdict = hrhp_pkg::STAT_REJECTED;
                            end
                            else begin
                                ph_next  = hrhp_pkg::PH_LINE;
                                len_next = '0;
                                hc_step  = hc_reg + hrhp_pkg::HCNT_W'(1);
                            end
                        end
                        default:
                        begin
                            verdict = hrhp_pkg::STAT_REJECTED;
                        end
                    endcase
                end
                else begin
                    // lone CR is an ordinary field byte
                    if (t_cr.reject) begin
                        verdict = hrhp_pkg::STAT_REJECTED;
                    end
                    else begin
                        ph_next  = t_cr.ph;
                        len_next = t_cr.len;
                        e0       = t_cr.emit;
                        k0       = t_cr.kind;
                        if (data_byte == hrhp_pkg::CH_CR) begin
                            cr_next = 1'b1;
                        end
                        else if (t_after_cr.reject) begin
                            verdict = hrhp_pkg::STAT_REJECTED;
                        end
                        else begin
                            ph_next  = t_after_cr.ph;
                            len_next = t_after_cr.len;
                            e1       = t_after_cr.emit;
                            k1       = t_after_cr.kind;
                        end
                    end
                end
            end
            else if (data_byte == hrhp_pkg::CH_CR) begin
                cr_next = 1'b1;
            end
            else begin
                if (t_plain.reject) begin
                    verdict = hrhp_pkg::STAT_REJECTED;
                end
                else begin
                    ph_next  = t_plain.ph;
                    len_next = t_plain.len;
                    e0       = t_plain.emit;
                    c0       = data_byte;
                    k0       = t_plain.kind;
                end
            end

            if ((verdict == hrhp_pkg::STAT_PARSING) && end_of_request) begin
                verdict = hrhp_pkg::STAT_REJECTED;
            end

            hc_next = hc_step;

            if (verdict != hrhp_pkg::STAT_PARSING) begin
                // verdict is the only result of this byte
                push.cnt             = 2'd1;
                push.r0.char_out     = 8'd0;
                push.r0.field_kind   = hrhp_pkg::KIND_VERDICT;
                push.r0.header_index = 6'd0;
                push.r0.status       = verdict;
                push.r0.header_total = hc_step;
                push.r0.last_of_run  = 1'b1;
                cr_next              = 1'b0;
                if (end_of_request) begin
                    ph_next  = hrhp_pkg::PH_METHOD;
                    len_next = '0;
                    hc_next  = '0;
                end
                else begin
                    ph_next = hrhp_pkg::PH_DONE;
                end
            end
            else begin
                res0.char_out     = c0;
                res0.field_kind   = k0;
                res0.header_index = (k0 >= hrhp_pkg::KIND_NAME) ? hc_step[5:0] : 6'd0;
                res0.status       = hrhp_pkg::STAT_PARSING;
                res0.header_total = hc_step;
                res0.last_of_run  = 1'b1;
                res1.char_out     = c1;
                res1.field_kind   = k1;
                res1.header_index = (k1 >= hrhp_pkg::KIND_NAME) ? hc_step[5:0] : 6'd0;
                res1.status       = hrhp_pkg::STAT_PARSING;
                res1.header_total = hc_step;
                res1.last_of_run  = 1'b1;
                if (e0 && e1) begin
                    push.cnt             = 2'd2;
                    push.r0              = res0;
                    push.r0.last_of_run  = 1'b0;
                    push.r1              = res1;
                end
                else if (e0) begin
                    push.cnt = 2'd1;
                    push.r0  = res0;
                end
                else if (e1) begin
                    push.cnt = 2'd1;
                    push.r0  = res1;
                end
            end
        end
    end

endmodule

[hdl/hrhp_outq.sv]
// ----------------------------------------------------------------------------
// hrhp_outq
// Small result queue: takes up to two results a cycle, gives one on rd_ready.
// ----------------------------------------------------------------------------
module hrhp_outq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  hrhp_pkg::push_t    push,
    output logic               room,
    output logic               rd_valid,
    input  logic               rd_ready,
    output hrhp_pkg::result_t  rd_data
);

    hrhp_pkg::result_t                  q_mem [hrhp_pkg::OQ_DEPTH];
    logic [hrhp_pkg::OQ_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [hrhp_pkg::OQ_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [hrhp_pkg::OQ_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [1:0]                         n_in;
    logic                               pop;

    assign n_in = wr_en ? push.cnt : 2'd0;
    assign pop  = rd_valid && rd_ready;

    assign wr_ptr_next = wr_ptr_reg + hrhp_pkg::OQ_PTR_W'(n_in);
    assign rd_ptr_next = rd_ptr_reg + hrhp_pkg::OQ_PTR_W'(pop);
    assign cnt_next    = cnt_reg + hrhp_pkg::OQ_CNT_W'(n_in) - hrhp_pkg::OQ_CNT_W'(pop);

    // two free slots needed, since one byte may produce two results
    assign room     = (cnt_reg <= hrhp_pkg::OQ_CNT_W'(hrhp_pkg::OQ_DEPTH - 2));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_in != 2'd0) begin
            q_mem[wr_ptr_reg] <= push.r0;
        end
        if (n_in == 2'd2) begin
            q_mem[wr_ptr_reg + hrhp_pkg::OQ_PTR_W'(1)] <= push.r1;
        end
    end

endmodule

[hdl/http_request_head_parser.sv]
// ----------------------------------------------------------------------------
// http_request_head_parser
// Splits an HTTP/1.1 request head into tagged method, path, version, header
// name and header value bytes and ends each request with a verdict.
//
//   Channel   Dir  Fields
//   s_axis    in   tdata[7:0] data_byte, tlast end_of_request
//   m_axis    out  tdata char_out/header_index/status/header_total,
//                  tuser field_kind, tlast last_of_run
//   cfg       in   cfg_we, cfg_index (0..5), cfg_data (limits)
//
// One byte is taken per cycle while s_axis_tready is high and is parsed in
// the cycle it is accepted; its results land in a four-entry result queue,
// read one per cycle while m_axis_tready is high. A lone CR followed by another
// field byte yields two results. s_axis_tready drops while fewer than two
// queue slots are free. Reset clears parse state, queue and limits at once.
// ----------------------------------------------------------------------------
module http_request_head_parser
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] char_out, [13:8] header_index, [15:14] status,
    // [22:16] header_total, [23] zero
    output logic [23:0]                     m_axis_tdata,
    output logic [2:0]                      m_axis_tuser,  // [2:0] field_kind
    output logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [hrhp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hrhp_pkg::CFG_DATA_W-1:0] cfg_data
);

    hrhp_pkg::limits_t  lim;
    hrhp_pkg::push_t    push;
    hrhp_pkg::result_t  res;
    logic               room;
    logic               accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    hrhp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lim       (lim)
    );

    hrhp_parse u_parse
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (s_axis_tdata),
        .end_of_request (s_axis_tlast),
        .lim            (lim),
        .push           (push)
    );

    hrhp_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .push     (push),
        .room     (room),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_data  (res)
    );

    assign m_axis_tdata = {1'b0, res.header_total, res.status, res.header_index, res.char_out};
    assign m_axis_tuser = res.field_kind;
    assign m_axis_tlast = res.last_of_run;

endmodule

[bench/hrhp_result_checker.sv]
// ----------------------------------------------------------------------------
// hrhp_result_checker
// Watches the request, result and configuration ports of the HTTP request
// head parser. Keeps its own parse state and limits, predicts the tagged
// bytes and verdicts for each accepted request byte, and checks every result
// against the oldest prediction.
// ----------------------------------------------------------------------------
module hrhp_result_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,
    input  logic                            s_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [23:0]                     m_axis_tdata,
    input  logic [2:0]                      m_axis_tuser,
    input  logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [hrhp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hrhp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              bytes_parsed,
    output int                              results_seen,
    output int                              accepts,
    output int                              rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    // limits
    logic [4:0]  lim_method;
    logic [12:0] lim_path;
    logic [6:0]  lim_version;
    logic [8:0]  lim_name;
    logic [12:0] lim_value;
    logic [6:0]  lim_hdr;

    // parse state
    hrhp_pkg::phase_t ph;
    logic             cr_held;
    logic [12:0]      flen;
    logic [6:0]       hcnt;

    // field bytes produced by the byte being parsed
    logic [7:0]  step_ch[2];
    logic [2:0]  step_kind[2];
    int          step_n;

    hrhp_pkg::result_t expected_results[$];
    int                err_n;
    int                parsed_n;
    int                seen_n;
    int                acc_n;
    int                rej_n;

    function automatic void clear_parse();
        ph      = hrhp_pkg::PH_METHOD;
        cr_held = 1'b0;
        flen    = '0;
        hcnt    = '0;
    endfunction

    function automatic logic [12:0] cur_limit();
        case (ph)
            hrhp_pkg::PH_METHOD:  return 13'(lim_method);
            hrhp_pkg::PH_PATH:    return lim_path;
            hrhp_pkg::PH_VERSION: return 13'(lim_version);
            hrhp_pkg::PH_NAME:    return 13'(lim_name);
            default:              return lim_value;
        endcase
    endfunction

    function automatic logic [1:0] note_char(input logic [7:0] ch, input logic [2:0] kind);
        if (({1'b0, flen} + 14'd1) >= {1'b0, cur_limit()})
            return hrhp_pkg::STAT_REJECTED;
        flen = flen + 13'd1;
        if (step_n < 2) begin
            step_ch[step_n]   = ch;
            step_kind[step_n] = kind;
            step_n++;
        end
        return hrhp_pkg::STAT_PARSING;
    endfunction

    // a zero limit rejects even an empty field here
    function automatic logic [1:0] close_field(input hrhp_pkg::phase_t nxt);
        if (flen >= cur_limit())
            return hrhp_pkg::STAT_REJECTED;
        ph   = nxt;
        flen = '0;
        return hrhp_pkg::STAT_PARSING;
    endfunction

    function automatic logic [1:0] take_char(input logic [7:0] b);
        if (ph == hrhp_pkg::PH_LINE) begin
            if (hcnt >= lim_hdr)
                return hrhp_pkg::STAT_REJECTED;
            ph   = hrhp_pkg::PH_NAME;
            flen = '0;
        end
        case (ph)
            hrhp_pkg::PH_METHOD:
                return (b == hrhp_pkg::CH_SP) ? close_field(hrhp_pkg::PH_PATH)
                                              : note_char(b, hrhp_pkg::KIND_METHOD);
            hrhp_pkg::PH_PATH:
                return (b == hrhp_pkg::CH_SP) ? close_field(hrhp_pkg::PH_VERSION)
                                              : note_char(b, hrhp_pkg::KIND_PATH);
            hrhp_pkg::PH_VERSION:
                return note_char(b, hrhp_pkg::KIND_VERSION);
            hrhp_pkg::PH_NAME:
                return (b == hrhp_pkg::CH_COLON) ? close_field(hrhp_pkg::PH_SKIP)
                                                 : note_char(b, hrhp_pkg::KIND_NAME);
            hrhp_pkg::PH_SKIP:
            begin
                if (b == hrhp_pkg::CH_SP)
                    return hrhp_pkg::STAT_PARSING;
                ph = hrhp_pkg::PH_VALUE;
                return note_char(b, hrhp_pkg::KIND_VALUE);
            end
            hrhp_pkg::PH_VALUE:
                return note_char(b, hrhp_pkg::KIND_VALUE);
            default:
                return hrhp_pkg::STAT_PARSING;
        endcase
    endfunction

    function automatic logic [1:0] line_break();
        logic [1:0] v;
        case (ph)
            hrhp_pkg::PH_VERSION:
                return close_field(hrhp_pkg::PH_LINE);
            hrhp_pkg::PH_LINE:
                return hrhp_pkg::STAT_ACCEPTED;
            hrhp_pkg::PH_SKIP, hrhp_pkg::PH_VALUE:
            begin
                v = close_field(hrhp_pkg::PH_LINE);
                if (v == hrhp_pkg::STAT_PARSING)
                    hcnt = hcnt + 7'd1;
                return v;
            end
            default:
                return hrhp_pkg::STAT_REJECTED;
        endcase
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic eor);
        logic [1:0]        v;
        hrhp_pkg::result_t r;
        if (ph == hrhp_pkg::PH_DONE) begin
            // waiting for the end of the buffer
            if (eor)
                clear_parse();
            return;
        end
        parsed_n++;
        step_n = 0;
        v      = hrhp_pkg::STAT_PARSING;
        if (b == hrhp_pkg::CH_NUL) begin
            v = hrhp_pkg::STAT_REJECTED;
        end
        else if (cr_held) begin
            cr_held = 1'b0;
            if (b == hrhp_pkg::CH_LF) begin
                v = line_break();
            end
            else begin
                // lone CR is an ordinary field byte
                v = take_char(hrhp_pkg::CH_CR);
                if (v == hrhp_pkg::STAT_PARSING) begin
                    if (b == hrhp_pkg::CH_CR)
                        cr_held = 1'b1;
                    else
                        v = take_char(b);
                end
            end
        end
        else if (b == hrhp_pkg::CH_CR) begin
            cr_held = 1'b1;
        end
        else begin
            v = take_char(b);
        end
        if (v == hrhp_pkg::STAT_PARSING && eor)
            v = hrhp_pkg::STAT_REJECTED;

        if (v != hrhp_pkg::STAT_PARSING) begin
            r              = '0;
            r.field_kind   = hrhp_pkg::KIND_VERDICT;
            r.status       = v;
            r.header_total = hcnt;
            r.last_of_run  = 1'b1;
            expected_results.push_back(r);
            if (v == hrhp_pkg::STAT_ACCEPTED)
                acc_n++;
            else
                rej_n++;
            if (eor) begin
                clear_parse();
            end
            else begin
                ph      = hrhp_pkg::PH_DONE;
                cr_held = 1'b0;
            end
        end
        else begin
            for (int k = 0; k < step_n; k++) begin
                r.char_out     = step_ch[k];
                r.field_kind   = step_kind[k];
                r.header_index = (step_kind[k] >= hrhp_pkg::KIND_NAME) ? hcnt[5:0] : 6'd0;
                r.status       = hrhp_pkg::STAT_PARSING;
                r.header_total = hcnt;
                r.last_of_run  = (k == step_n - 1);
                expected_results.push_back(r);
            end
        end
    endtask

    task automatic write_limit(input logic [hrhp_pkg::CFG_IDX_W-1:0] idx,
                               input logic [hrhp_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            hrhp_pkg::REG_METHOD_LIMIT:  lim_method  = val[4:0];
            hrhp_pkg::REG_PATH_LIMIT:    lim_path    = val[12:0];
            hrhp_pkg::REG_VERSION_LIMIT: lim_version = val[6:0];
            hrhp_pkg::REG_NAME_LIMIT:    lim_name    = val[8:0];
            hrhp_pkg::REG_VALUE_LIMIT:   lim_value   = val[12:0];
            hrhp_pkg::REG_HEADER_LIMIT:  lim_hdr     = val[6:0];
            default: ;
        endcase
    endtask

    task automatic check_result();
        hrhp_pkg::result_t got;
        hrhp_pkg::result_t want;
        got.char_out     = m_axis_tdata[7:0];
        got.header_index = m_axis_tdata[13:8];
        got.status       = m_axis_tdata[15:14];
        got.header_total = m_axis_tdata[22:16];
        got.field_kind   = m_axis_tuser;
        got.last_of_run  = m_axis_tlast;
        if (expected_results.size() == 0) begin
            err_n++;
            $display("%0t: unexpected result, expected none", $time);
            $display("    actual   char=%02h kind=%0d idx=%0d status=%0d total=%0d last=%0b",
                     got.char_out, got.field_kind, got.header_index,
                     got.status, got.header_total, got.last_of_run);
        end
        else begin
            want = expected_results.pop_front();
            seen_n++;
            if (got.char_out !== want.char_out || got.field_kind !== want.field_kind ||
                got.header_index !== want.header_index || got.status !== want.status ||
                got.header_total !== want.header_total ||
                got.last_of_run !== want.last_of_run || m_axis_tdata[23] !== 1'b0) begin
                err_n++;
                $display("%0t: result mismatch", $time);
                $display("    expected char=%02h kind=%0d idx=%0d status=%0d total=%0d %s",
                         want.char_out, want.field_kind, want.header_index,
                         want.status, want.header_total,
                         $sformatf("last=%0b pad=0", want.last_of_run));
                $display("    actual   char=%02h kind=%0d idx=%0d status=%0d total=%0d %s",
                         got.char_out, got.field_kind, got.header_index, got.status,
                         got.header_total,
                         $sformatf("last=%0b pad=%0b", got.last_of_run, m_axis_tdata[23]));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lim_method  = 5'd8;
            lim_path    = 13'd256;
            lim_version = 7'd16;
            lim_name    = 9'd64;
            lim_value   = 13'd256;
            lim_hdr     = 7'd32;
            clear_parse();
            expected_results.delete();
            err_n    = 0;
            parsed_n = 0;
            seen_n   = 0;
            acc_n    = 0;
            rej_n    = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (cfg_we)
                write_limit(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tlast);
        end
        mismatches   <= err_n;
        outstanding  <= expected_results.size();
        bytes_parsed <= parsed_n;
        results_seen <= seen_n;
        accepts      <= acc_n;
        rejects      <= rej_n;
    end

endmodule

[bench/tb_http_request_head_parser.sv]
// ----------------------------------------------------------------------------
// tb_http_request_head_parser
// Drives request bytes into the HTTP request head parser under several limit
// settings: a few hand-made requests, then mostly well-formed random requests
// with some corrupted ones and noise, with random gaps and stalls on both
// streams and one long output stall. Checking is done by hrhp_result_checker.
// ----------------------------------------------------------------------------
module tb_http_request_head_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    // indexes past the register list, written to check they are ignored
    localparam logic [hrhp_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [hrhp_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [23:0]                     m_axis_tdata;
    logic [2:0]                      m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            cfg_we = 1'b0;
    logic [hrhp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hrhp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int outstanding;
    int bytes_parsed;
    int results_seen;
    int accepts;
    int rejects;

    int cycles = 0;
    bit quiet = 1'b0;
    int hold_req = 0;

    // limits as last written, used to shape the requests
    int lim_m = 8;
    int lim_p = 256;
    int lim_v = 16;
    int lim_n = 64;
    int lim_val = 256;
    int lim_h = 32;

    logic [7:0] req_bytes[$];

    always #6 clk = ~clk;

    http_request_head_parser dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    hrhp_result_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .bytes_parsed  (bytes_parsed),
        .results_seen  (results_seen),
        .accepts       (accepts),
        .rejects       (rejects)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    int hold_seen = 0;
    int hold_left = 0;
    always @(negedge clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 34);
        end
    end

    // called right after a falling edge; returns right after one
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!quiet && $urandom_range(0, 99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_request();
        int i;
        for (i = 0; i < req_bytes.size(); i++)
            send_byte(req_bytes[i], i == req_bytes.size() - 1);
    endtask

    // stop the request stream and let every expected result drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [hrhp_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[hrhp_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
    endtask

    task automatic set_limits(input int m, input int p, input int v,
                              input int n, input int val, input int h);
        settle();
        write_reg(hrhp_pkg::REG_METHOD_LIMIT, m);
        write_reg(hrhp_pkg::REG_PATH_LIMIT, p);
        write_reg(hrhp_pkg::REG_VERSION_LIMIT, v);
        write_reg(hrhp_pkg::REG_NAME_LIMIT, n);
        write_reg(hrhp_pkg::REG_VALUE_LIMIT, val);
        write_reg(hrhp_pkg::REG_HEADER_LIMIT, h);
        cfg_we <= 1'b0;
        lim_m   = m & 32'h1F;
        lim_p   = p & 32'h1FFF;
        lim_v   = v & 32'h7F;
        lim_n   = n & 32'h1FF;
        lim_val = val & 32'h1FFF;
        lim_h   = h & 32'h7F;
    endtask

    function automatic void put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endfunction

    function automatic void put_crlf();
        req_bytes.push_back(hrhp_pkg::CH_CR);
        req_bytes.push_back(hrhp_pkg::CH_LF);
    endfunction

    function automatic logic [7:0] field_char(input bit for_name);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_LF || c == hrhp_pkg::CH_SP ||
               (for_name && c == hrhp_pkg::CH_COLON));
        return c;
    endfunction

    // mostly lengths inside the limit, now and then right at it if it is ten or less
    function automatic void add_field(input int lim, input bit for_name);
        int cap;
        int hi;
        int lo;
        int n;
        int i;
        cap = (lim > 10) ? 10 : lim;
        hi  = (cap > 0) ? cap - 1 : 0;
        lo  = (hi > 0) ? 1 : 0;
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(0, cap);
        else
            n = $urandom_range(lo, hi);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
                req_bytes.push_back(hrhp_pkg::CH_CR);
            req_bytes.push_back(field_char(for_name));
        end
    endfunction

    function automatic void build_request();
        int hcap;
        int nh;
        int r;
        int pos;
        req_bytes.delete();
        add_field(lim_m, 1'b0);
        req_bytes.push_back(hrhp_pkg::CH_SP);
        add_field(lim_p, 1'b0);
        req_bytes.push_back(hrhp_pkg::CH_SP);
        add_field(lim_v, 1'b0);
        put_crlf();
        hcap = (lim_h + 1 > 4) ? 4 : lim_h + 1;
        nh   = $urandom_range(0, hcap);
        repeat (nh) begin
            add_field(lim_n, 1'b1);
            req_bytes.push_back(hrhp_pkg::CH_COLON);
            repeat ($urandom_range(0, 2)) req_bytes.push_back(hrhp_pkg::CH_SP);
            add_field(lim_val, 1'b0);
            put_crlf();
        end
        put_crlf();
        // trailing bytes after the head are ignored until the end mark
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) req_bytes.push_back(8'($urandom_range(0, 255)));

        r   = $urandom_range(0, 99);
        pos = $urandom_range(0, req_bytes.size() - 1);
        if (r < 12) begin
            req_bytes[pos] = 8'($urandom_range(0, 255));
        end
        else if (r < 18) begin
            while (req_bytes.size() > pos + 1)
                void'(req_bytes.pop_back());
        end
        else if (r < 22) begin
            if (req_bytes.size() > 1)
                req_bytes.delete(pos);
        end
        else if (r < 26) begin
            req_bytes.insert(pos, hrhp_pkg::CH_CR);
        end
    endfunction

    task automatic run_phase(input int n_bytes);
        int goal;
        goal = bytes_parsed + n_bytes;
        while (bytes_parsed < goal) begin
            if ($urandom_range(0, 19) == 0) begin
                req_bytes.delete();
                repeat ($urandom_range(1, 8)) req_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else begin
                build_request();
            end
            send_request();
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // accepted head with top byte value and skipped value spaces
        req_bytes.delete();
        req_bytes.push_back(8'hFF);
        put_text(" / V");
        put_crlf();
        put_text("N:  x");
        put_crlf();
        put_crlf();
        send_request();
        // lone CR, then CRLF inside the method, then ignored bytes
        req_bytes.delete();
        put_text("a");
        req_bytes.push_back(hrhp_pkg::CH_CR);
        put_text("b");
        put_crlf();
        put_text("zq");
        send_request();
        // zero byte while a CR is held
        req_bytes.delete();
        put_text("x");
        req_bytes.push_back(hrhp_pkg::CH_CR);
        req_bytes.push_back(hrhp_pkg::CH_NUL);
        send_request();
        // end of buffer in the middle of the method
        req_bytes.delete();
        put_text("m");
        send_request();

        run_phase(230);

        // tight limits, with a long output stall at the start
        set_limits(4, 8, 6, 5, 6, 2);
        hold_req++;
        run_phase(200);

        // larger limits, no idling on either side
        set_limits(16, 4096, 64, 256, 4096, 64);
        quiet = 1'b1;
        run_phase(200);
        quiet = 1'b0;

        // limits of one: only empty fields and no headers pass
        set_limits(1, 1, 1, 1, 1, 0);
        run_phase(100);

        // zero limits reject even empty fields
        set_limits(0, 3, 2, 0, 2, 1);
        run_phase(80);

        // all-ones data is masked to each register's width
        set_limits(8191, 8191, 8191, 8191, 8191, 8191);
        write_reg(REG_SPARE_6, 0);
        write_reg(REG_SPARE_7, 0);
        cfg_we <= 1'b0;
        run_phase(150);

        set_limits($urandom_range(1, 12), $urandom_range(1, 20), $urandom_range(1, 12),
                   $urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 4));
        run_phase(200);

        settle();
        $display("Covered %0d parsed request bytes over seven limit settings, %0d results checked",
                 bytes_parsed, results_seen);
        $display("Verdicts: %0d accepted, %0d rejected", accepts, rejects);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
